// ----- hdl/mtsg_pkg.sv -----
package mtsg_pkg;

  localparam int NUM_TONES        = 4;
  localparam int MAX_TONES        = 4;
  localparam int SINE_TABLE_DEPTH = 1024;

  localparam int TAB_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int QBITS    = TAB_BITS - 2;
  localparam int QDEPTH   = SINE_TABLE_DEPTH / 4;

  localparam int PH_W       = 16;
  localparam int GATE_W     = 12;
  localparam int GPR_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int PROD_W     = 31;
  localparam int ACC_W      = PROD_W + $clog2(NUM_TONES + 1);
  localparam int SCALED_W   = ACC_W + 17;
  localparam int FIFO_DEPTH = 2;
  localparam int BACK_STAGES = 5;

  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598669;
  localparam logic [63:0] C5 = 64'd85569304;
  localparam logic [63:0] C7 = 64'd5026995;
  localparam logic [63:0] C9 = 64'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_A       = 3'd0,
    REG_TONE_B       = 3'd1,
    REG_TONE_C       = 3'd2,
    REG_TONE_D       = 3'd3,
    REG_DC_SUM       = 3'd4,
    REG_POWER_GAIN   = 3'd5,
    REG_POWER_CENTER = 3'd6,
    REG_GATES        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] gain;
    logic [PH_W-1:0]    start;
    logic [PH_W-1:0]    step;
  } tone_t;

  typedef struct packed {
    tone_t [MAX_TONES-1:0] tone;
    logic signed [15:0]    dc_sum;
    logic [15:0]           power_gain;
    logic signed [15:0]    power_center;
    logic [GPR_W-1:0]      gates;
  } cfg_t;

  // One sample in flight: quarter-table address and sign per tone, plus the gate marker.
  typedef struct packed {
    logic [NUM_TONES-1:0][QBITS:0] addr;
    logic [NUM_TONES-1:0]          neg;
    logic                          last;
  } item_t;

  typedef logic [14:0] qtab_t [QDEPTH+1];

  function automatic logic [14:0] quarter_sine(input logic [63:0] j);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] m;
    u  = (j << 30) >> QBITS;
    u2 = (u * u) >> 30;
    t  = C9;
    t  = C7 - ((u2 * t) >> 30);
    t  = C5 - ((u2 * t) >> 30);
    t  = C3 - ((u2 * t) >> 30);
    t  = C1 - ((u2 * t) >> 30);
    s  = (u * t) >> 30;
    m  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (m > 64'd32767) ? 15'd32767 : m[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int k = 0; k <= QDEPTH; k++) begin
      tab[k] = quarter_sine(64'(k));
    end
    return tab;
  endfunction

  // Quarter wave, both ends included so mirrored quadrants need no special case.
  localparam qtab_t QSINE = build_qtab();

endpackage

// ----- hdl/mtsg_if.sv -----
interface mtsg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface mtsg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last_gate;

  modport source (output valid, output sample, output last_gate, input ready);
  modport sink   (input valid, input sample, input last_gate, output ready);
endinterface

// ----- hdl/mtsg_fifo.sv -----
module mtsg_fifo
  import mtsg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rptr_q];

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// ----- hdl/mtsg_front.sv -----
module mtsg_front
  import mtsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  mtsg_in_if.sink     in_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [PH_W-1:0]   phase_q [NUM_TONES];
  logic [PH_W-1:0]   phase_d [NUM_TONES];
  logic [PH_W-1:0]   ph      [NUM_TONES];
  logic [GATE_W-1:0] gate_q, gate_d, gate_cur, last_lim;
  logic              accept;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;

  always_comb begin
    logic [TAB_BITS-1:0] idx;
    logic [QBITS-1:0]    j;
    item_o = '0;
    for (int i = 0; i < NUM_TONES; i++) begin
      ph[i]  = in_i.restart ? cfg_i.tone[i].start : phase_q[i];
      idx    = ph[i][PH_W-1 -: TAB_BITS];
      j      = idx[QBITS-1:0];
      // odd quadrants run the quarter wave backwards, the upper half is negated
      item_o.addr[i] = idx[TAB_BITS-2] ? ((QBITS+1)'(QDEPTH) - {1'b0, j}) : {1'b0, j};
      item_o.neg[i]  = idx[TAB_BITS-1];
      phase_d[i]     = ph[i] + cfg_i.tone[i].step;
    end

    // clamp the gate count into 1..4096
    if (cfg_i.gates == '0) begin
      last_lim = '0;
    end else if (cfg_i.gates[GPR_W-1]) begin
      last_lim = '1;
    end else begin
      last_lim = cfg_i.gates[GATE_W-1:0] - 1'b1;
    end

    gate_cur    = in_i.restart ? '0 : gate_q;
    item_o.last = (gate_cur >= last_lim);
    gate_d      = item_o.last ? '0 : gate_cur + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        phase_q[i] <= '0;
      end
      gate_q <= '0;
    end else if (accept) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        phase_q[i] <= phase_d[i];
      end
      gate_q <= gate_d;
    end
  end

endmodule

// ----- hdl/mtsg_back.sv -----
module mtsg_back
  import mtsg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        empty_i,
  input  item_t       item_i,
  output logic        pop_o,
  mtsg_out_if.source  out_o
);

  localparam int Q_W = SCALED_W - 30;
  localparam int V_W = Q_W + 2;

  logic [BACK_STAGES-1:0] v_q;
  logic                   en;

  logic signed [15:0]       sine_q [NUM_TONES];
  logic signed [15:0]       sine_d [NUM_TONES];
  logic signed [PROD_W-1:0] prod_q [NUM_TONES];
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [SCALED_W-1:0] scaled_q;
  logic [BACK_STAGES-2:0]   last_q;
  logic signed [15:0]       sample_q, sample_d;
  logic                     last_gate_q;

  logic signed [Q_W-1:0] quo;
  logic [29:0]           frac;
  logic                  rnd_up;
  logic signed [V_W-1:0] v;

  // the whole pipe advances together whenever the output register can move
  assign en    = !v_q[BACK_STAGES-1] || out_o.ready;
  assign pop_o = en && !empty_i;

  assign out_o.valid     = v_q[BACK_STAGES-1];
  assign out_o.sample    = sample_q;
  assign out_o.last_gate = last_gate_q;

  always_comb begin
    logic [15:0] mag;
    for (int i = 0; i < NUM_TONES; i++) begin
      mag       = {1'b0, QSINE[item_i.addr[i]]};
      sine_d[i] = item_i.neg[i] ? -$signed(mag) : $signed(mag);
    end

    acc_d = ACC_W'(cfg_i.dc_sum) <<< 15;
    for (int i = 0; i < NUM_TONES; i++) begin
      acc_d = acc_d + ACC_W'(prod_q[i]);
    end

    // divide by 2^30, round half to even, offset and clip
    quo    = Q_W'(scaled_q >>> 30);
    frac   = scaled_q[29:0];
    rnd_up = (frac > 30'h2000_0000) || ((frac == 30'h2000_0000) && quo[0]);
    v      = V_W'(quo) + V_W'($signed({1'b0, rnd_up})) + V_W'(cfg_i.power_center);
    if (v > V_W'(32767)) begin
      sample_d = 16'sh7FFF;
    end else if (v < -V_W'(32768)) begin
      sample_d = 16'sh8000;
    end else begin
      sample_d = v[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[BACK_STAGES-2:0], !empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        sine_q[i] <= sine_d[i];
        prod_q[i] <= PROD_W'(sine_q[i]) * PROD_W'($signed(cfg_i.tone[i].gain));
      end
      acc_q       <= acc_d;
      scaled_q    <= SCALED_W'(acc_q) * SCALED_W'($signed({1'b0, cfg_i.power_gain}));
      last_q      <= {last_q[BACK_STAGES-3:0], item_i.last};
      sample_q    <= sample_d;
      last_gate_q <= last_q[BACK_STAGES-2];
    end
  end

endmodule

// ----- hdl/multi_tone_sine_sample_generator.sv -----
// Path: the queue, then sine, product, sum, scale and output registers.
// Throughput: one sample per cycle while the output side takes results; the
// five-stage back pipe and a two-entry queue after the phase front set this.
// Reset: config registers to their reset values, tone phases and gate count to zero,
// queue and pipe emptied.
module multi_tone_sine_sample_generator
  import mtsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mtsg_in_if.sink               in_i,
  mtsg_out_if.source            out_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push, full, pop, empty;
  item_t push_item, pop_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i)) inside
        REG_TONE_A, REG_TONE_B, REG_TONE_C, REG_TONE_D: begin
          cfg_d.tone[cfg_idx_i[1:0]] = tone_t'(cfg_data_i[47:0]);
        end
        REG_DC_SUM:       cfg_d.dc_sum       = cfg_data_i[15:0];
        REG_POWER_GAIN:   cfg_d.power_gain   = cfg_data_i[15:0];
        REG_POWER_CENTER: cfg_d.power_center = cfg_data_i[15:0];
        REG_GATES:        cfg_d.gates        = cfg_data_i[GPR_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tone: '0, dc_sum: '0, power_gain: 16'd8192, power_center: '0,
                 gates: GPR_W'(4096)};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mtsg_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  mtsg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  mtsg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .item_i  (pop_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- hdl/mtsg_checker.sv -----
module mtsg_checker
  import mtsg_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] sample_i,
  input logic               last_gate_i
);

  localparam int MAX_INFLIGHT = FIFO_DEPTH + BACK_STAGES;
  localparam int CNT_W        = $clog2(MAX_INFLIGHT + 2);

  logic [CNT_W-1:0] inflight_q;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(sample_i) && $stable(last_gate_i))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> inflight_q != '0)
    else $error("result shown with no sample outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(MAX_INFLIGHT))
    else $error("more samples in flight than queue and pipe hold");

endmodule

bind multi_tone_sine_sample_generator mtsg_checker u_mtsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sample_i    (out_o.sample),
  .last_gate_i (out_o.last_gate)
);
